>>> rtl/nsfc_pkg.sv
// ----------------------------------------------------------------------------
// nsfc_pkg
// Shared types, constants and helper functions for the NMEA sentence framer
// and checksum checker.
// ----------------------------------------------------------------------------
`default_nettype none

package nsfc_pkg;

    // Line buffer capacity; a line holds at most LINE_CAPACITY-1 characters.
    localparam int LINE_CAPACITY = 128;
    localparam int LEN_W         = $clog2(LINE_CAPACITY);
    localparam int CMP_W         = LEN_W + 7;
    localparam int PREFIX_LEN    = 7;
    localparam int NUM_PREFIX    = 8;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // Checksum digit tracker codes
    localparam logic [1:0] STAR_NO_DIGIT  = 2'd0;
    localparam logic [1:0] STAR_ONE_DIGIT = 2'd1;
    localparam logic [1:0] STAR_TWO_DIGIT = 2'd2;
    localparam logic [1:0] STAR_MALFORMED = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OVERFLOW = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_UNKNOWN  = 3'd2;
    localparam logic [2:0] ST_GGA      = 3'd3;

    typedef struct packed {
        logic [31:0] char_count;
        logic [31:0] checksum_failure_count;
        logic [31:0] sentence_count;
        logic        from_multi_constellation;
        logic [6:0]  line_length;
        logic [7:0]  received_checksum;
        logic [7:0]  computed_checksum;
        logic [2:0]  status;
    } t_result;

    // Character of candidate prefix k at position pos (0..6).
    function automatic logic [7:0] prefix_char(input logic [2:0] k, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (pos)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = "G";
            3'd2: ch = k[0] ? "N" : "P";
            3'd3: ch = (k[2:1] == 2'd0) ? "G" : (k[2:1] == 2'd1) ? "R" : "G";
            3'd4: ch = (k[2:1] == 2'd0) ? "G" : (k[2:1] == 2'd1) ? "M" : "S";
            3'd5: ch = (k[2:1] == 2'd0) ? "A" : (k[2:1] == 2'd1) ? "C" :
                       (k[2:1] == 2'd2) ? "V" : "A";
            3'd6: ch = ",";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Returns {valid, value} for a hex digit in either case.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= "0" && c <= "9") begin
            r = {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            r = {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            r = {1'b1, 4'(c - "A" + 8'd10)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/nmea_sentence_framer_checker_core.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_core
// Assembles received bytes into NMEA lines and reports framing, checksum,
// sentence type and running counters at each line end.
// Timing: a transferred byte is held in the input register; its result is
// loaded into the output register when that byte is processed.
// Throughput: one byte per cycle; the line state update is a single
// registered pass per byte, stalled only while a waiting result blocks.
// Reset: synchronous active-low i_rst_n clears line state, counters and
// both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer_checker_core
    import nsfc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    output      logic [127:0] m_tdata    // [2:0] status, [10:3] computed_checksum,
                                         // [18:11] received_checksum, [25:19] line_length,
                                         // [26] from_multi_constellation,
                                         // [58:27] sentence_count,
                                         // [90:59] checksum_failure_count,
                                         // [122:91] char_count, [127:123] zero
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // Line state
    logic [LEN_W-1:0] r_len,    n_len;
    logic             r_discard, n_discard;
    logic [7:0]       r_xor,    n_xor;
    logic [1:0]       r_star,   n_star;
    logic [7:0]       r_digits, n_digits;
    logic [8:0]       r_pref,   n_pref;
    logic             r_ended,  n_ended;
    logic [31:0]      r_sent,   n_sent;
    logic [31:0]      r_fail,   n_fail;
    logic [31:0]      r_bytes,  n_bytes;

    // Output register
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;
    logic    emit;
    logic    advance;

    // Process the held byte unless it makes a result and the output is blocked.
    assign advance  = r_in_valid && (!emit || !r_out_valid || m_tready);
    assign s_tready = !r_in_valid || advance;

    always_comb begin
        logic [7:0] c;
        logic [4:0] hv;
        logic       good;
        logic       take;
        logic       restart;
        c = r_in_byte;
        hv = 5'b0;
        good = 1'b0;
        take = 1'b0;
        restart = 1'b0;
        n_len    = r_len;
        n_discard = r_discard;
        n_xor    = r_xor;
        n_star   = r_star;
        n_digits = r_digits;
        n_pref   = r_pref;
        n_ended  = r_ended;
        n_sent   = r_sent;
        n_fail   = r_fail;
        n_bytes  = r_bytes + 32'd1;
        emit     = 1'b0;
        n_out    = '0;

        if (c == CH_LF) begin
            if (r_discard) begin
                n_discard = 1'b0;
                restart = 1'b1;
                n_sent = r_sent + 32'd1;
                emit = 1'b1;
                n_out.status = ST_OVERFLOW;
            end else if (r_len != '0) begin
                good = r_pref[8] && r_ended && (r_star == STAR_TWO_DIGIT) &&
                       (r_xor == r_digits);
                n_sent = r_sent + 32'd1;
                emit = 1'b1;
                n_out.status = ST_BAD;
                if (!good) begin
                    n_fail = r_fail + 32'd1;
                end else begin
                    n_out.status = ST_UNKNOWN;
                    if (CMP_W'(r_len) >= CMP_W'(PREFIX_LEN)) begin
                        for (int k = NUM_PREFIX - 1; k >= 0; k--) begin
                            if (r_pref[k]) begin
                                n_out.status = ST_GGA + 3'(k >> 1);
                                n_out.from_multi_constellation = 1'(k & 1);
                            end
                        end
                    end
                end
                n_out.computed_checksum = r_xor;
                n_out.received_checksum = (r_star == STAR_TWO_DIGIT) ? r_digits : 8'h00;
                n_out.line_length = (CMP_W'(r_len) > CMP_W'(127)) ? 7'd127 : 7'(r_len);
                restart = 1'b1;
            end
        end else if (!r_discard && c != CH_CR) begin
            if (c == CH_DOLLAR && r_len != '0) begin
                restart = 1'b1;
                take = 1'b1;
            end else if (CMP_W'(r_len) < CMP_W'(LINE_CAPACITY - 1)) begin
                take = 1'b1;
            end else begin
                restart = 1'b1;
                n_discard = 1'b1;
            end
        end

        if (restart) begin
            n_len    = '0;
            n_xor    = 8'h00;
            n_star   = STAR_NO_DIGIT;
            n_digits = 8'h00;
            n_pref   = 9'h0FF;
            n_ended  = 1'b0;
        end

        if (take) begin
            if (n_len == '0) begin
                if (c == CH_DOLLAR) n_pref[8] = 1'b1;
                if (c == CH_STAR) n_ended = 1'b1;
            end
            if (CMP_W'(n_len) < CMP_W'(PREFIX_LEN)) begin
                for (int k = 0; k < NUM_PREFIX; k++) begin
                    if (prefix_char(3'(k), n_len[2:0]) != c) n_pref[k] = 1'b0;
                end
            end
            if (n_len != '0) begin
                if (!n_ended) begin
                    if (c == CH_STAR) n_ended = 1'b1;
                    else n_xor = n_xor ^ c;
                end else begin
                    hv = hex_value(c);
                    if ((n_star == STAR_NO_DIGIT || n_star == STAR_ONE_DIGIT) && hv[4]) begin
                        n_digits = {n_digits[3:0], hv[3:0]};
                        n_star   = n_star + 2'd1;
                    end else begin
                        n_star = STAR_MALFORMED;
                    end
                end
            end
            n_len = n_len + LEN_W'(1);
        end

        n_out.sentence_count         = n_sent;
        n_out.checksum_failure_count = n_fail;
        n_out.char_count             = n_bytes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_len       <= '0;
            r_discard   <= 1'b0;
            r_xor       <= 8'h00;
            r_star      <= STAR_NO_DIGIT;
            r_digits    <= 8'h00;
            r_pref      <= 9'h0FF;
            r_ended     <= 1'b0;
            r_sent      <= 32'd0;
            r_fail      <= 32'd0;
            r_bytes     <= 32'd0;
        end else begin
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (advance) begin
                r_len     <= n_len;
                r_discard <= n_discard;
                r_xor     <= n_xor;
                r_star    <= n_star;
                r_digits  <= n_digits;
                r_pref    <= n_pref;
                r_ended   <= n_ended;
                r_sent    <= n_sent;
                r_fail    <= n_fail;
                r_bytes   <= n_bytes;
            end
            if (advance && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'b0, r_out};

endmodule

`default_nettype wire

>>> tb/nsfc_result_checker.sv
// ----------------------------------------------------------------------------
// nsfc_result_checker
// Watches the byte and result streams of the NMEA framer, predicts the
// line verdict and counters for every byte transfer and compares each result
// transfer against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module nsfc_result_checker
    import nsfc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [7:0]   i_in_byte,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [127:0] i_out_data,
    output      int           o_fail_count,
    output      int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HELD   = LINE_CAPACITY - 1;
    localparam int SHOW_LIMIT = 10;

    // line state
    logic [6:0]  held_len;
    logic        dropping;
    logic [7:0]  xor_sum;
    logic [1:0]  digit_phase;
    logic [7:0]  digit_value;
    logic [7:0]  heads_alive;
    logic        dollar_first;
    logic        star_seen;
    // running counters
    logic [31:0] lines_ended;
    logic [31:0] lines_failed;
    logic [31:0] bytes_seen;

    t_result pending_results[$];
    int      mismatches = 0;

    function automatic logic [7:0] head_char(input int k, input int pos);
        logic [55:0] s;
        case (k)
            0: s = "$GPGGA,";
            1: s = "$GNGGA,";
            2: s = "$GPRMC,";
            3: s = "$GNRMC,";
            4: s = "$GPGSV,";
            5: s = "$GNGSV,";
            6: s = "$GPGSA,";
            default: s = "$GNGSA,";
        endcase
        return s[55 - 8 * pos -: 8];
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic string result_text(input t_result r);
        return $sformatf("st=%0d cks=%02h rcv=%02h len=%0d gn=%0d lines=%0d bad=%0d chars=%0d",
                         r.status, r.computed_checksum, r.received_checksum,
                         r.line_length, r.from_multi_constellation, r.sentence_count,
                         r.checksum_failure_count, r.char_count);
    endfunction

    task automatic restart_line();
        held_len     = '0;
        xor_sum      = '0;
        digit_phase  = STAR_NO_DIGIT;
        digit_value  = '0;
        heads_alive  = '1;
        dollar_first = 1'b0;
        star_seen    = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        int pos;
        int v;
        pos = int'(held_len);
        if (pos == 0) begin
            if (c == CH_DOLLAR) dollar_first = 1'b1;
            if (c == CH_STAR) star_seen = 1'b1;
        end
        if (pos < PREFIX_LEN) begin
            for (int k = 0; k < NUM_PREFIX; k++) begin
                if (head_char(k, pos) != c) heads_alive[k] = 1'b0;
            end
        end
        if (pos >= 1) begin
            if (!star_seen) begin
                if (c == CH_STAR) star_seen = 1'b1;
                else xor_sum = xor_sum ^ c;
            end else begin
                v = hex_digit(c);
                if (digit_phase < STAR_TWO_DIGIT && v >= 0) begin
                    digit_value = {digit_value[3:0], 4'(v)};
                    digit_phase = digit_phase + 2'd1;
                end else begin
                    digit_phase = STAR_MALFORMED;
                end
            end
        end
        held_len = 7'(pos + 1);
    endtask

    task automatic close_line(input t_result r);
        r.sentence_count         = lines_ended;
        r.checksum_failure_count = lines_failed;
        r.char_count             = bytes_seen;
        pending_results.push_back(r);
    endtask

    // Advance the line state by one received byte; queue a verdict at a line end.
    task automatic frame_byte(input logic [7:0] c);
        t_result r;
        bit      good;
        r = '0;
        bytes_seen = bytes_seen + 32'd1;
        if (c == CH_LF) begin
            if (dropping) begin
                dropping = 1'b0;
                restart_line();
                lines_ended = lines_ended + 32'd1;
                r.status = ST_OVERFLOW;
                close_line(r);
            end else if (held_len != 0) begin
                good = dollar_first && star_seen && digit_phase == STAR_TWO_DIGIT &&
                       xor_sum == digit_value;
                lines_ended = lines_ended + 32'd1;
                r.status            = ST_BAD;
                r.computed_checksum = xor_sum;
                r.received_checksum = (digit_phase == STAR_TWO_DIGIT) ? digit_value : 8'h00;
                r.line_length       = held_len;
                if (!good) begin
                    lines_failed = lines_failed + 32'd1;
                end else begin
                    r.status = ST_UNKNOWN;
                    if (held_len >= PREFIX_LEN) begin
                        for (int k = NUM_PREFIX - 1; k >= 0; k--) begin
                            if (heads_alive[k]) begin
                                r.status = ST_GGA + 3'(k >> 1);
                                r.from_multi_constellation = k[0];
                            end
                        end
                    end
                end
                close_line(r);
                restart_line();
            end
        end else if (!dropping && c != CH_CR) begin
            if (c == CH_DOLLAR && held_len != 0) begin
                restart_line();
                absorb_char(c);
            end else if (int'(held_len) < MAX_HELD) begin
                absorb_char(c);
            end else begin
                restart_line();
                dropping = 1'b1;
            end
        end
    endtask

    task automatic flag_failure(input string msg);
        mismatches++;
        if (mismatches <= SHOW_LIMIT) $display("%s", msg);
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            restart_line();
            dropping     = 1'b0;
            lines_ended  = '0;
            lines_failed = '0;
            bytes_seen   = '0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = t_result'(i_out_data[122:0]);
                if (pending_results.size() == 0) begin
                    flag_failure($sformatf("unexpected result: %s", result_text(got)));
                end else begin
                    want = pending_results.pop_front();
                    if (got != want || i_out_data[127:123] != '0) begin
                        flag_failure($sformatf("result mismatch: expected %s got %s pad=%0h",
                                               result_text(want), result_text(got),
                                               i_out_data[127:123]));
                    end
                end
            end
            if (i_in_valid && i_in_ready) frame_byte(i_in_byte);
        end
        o_fail_count <= mismatches;
        o_pending    <= pending_results.size();
    end

endmodule

`default_nettype wire

>>> tb/nmea_sentence_framer_checker_core_tb.sv
// ----------------------------------------------------------------------------
// nmea_sentence_framer_checker_core_tb
// Feeds the NMEA framer directed sentences covering every type, checksum
// and framing fault, overflow and line-restart case, then random sentence
// traffic mixed with broken lines and raw noise, with random stalls on both
// streams. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_sentence_framer_checker_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsfc_pkg::*;

    localparam int RANDOM_BYTES = 80;
    localparam int TAIL_CYCLES  = 20;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    int fail_count;
    int results_due;
    int bytes_sent = 0;
    bit steady     = 1'b0;

    always #5 i_clk = ~i_clk;

    nmea_sentence_framer_checker_core u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nsfc_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_byte    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    initial begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: hold ready low for a random stall before each transfer.
    initial begin
        int w;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            w = steady ? 0 : $urandom_range(0, 4);
            if (w > 0) begin
                m_tready <= 1'b0;
                repeat (w) @(negedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    function automatic string talker_head(input int k);
        case (k)
            0: return "GPGGA,";
            1: return "GNGGA,";
            2: return "GPRMC,";
            3: return "GNRMC,";
            4: return "GPGSV,";
            5: return "GNGSV,";
            6: return "GPGSA,";
            default: return "GNGSA,";
        endcase
    endfunction

    // Wrap a body in '$' and '*' plus its correct checksum.
    function automatic string checked(input string body, input bit lower);
        logic [7:0] x;
        x = 8'h00;
        for (int i = 0; i < body.len(); i++) x = x ^ body[i];
        return {"$", body, "*", lower ? $sformatf("%02x", x) : $sformatf("%02X", x)};
    endfunction

    // Printable text without '$' or '*'.
    function automatic string filler(input int n);
        string s;
        logic [7:0] c;
        s = "";
        for (int i = 0; i < n; i++) begin
            c = 8'($urandom_range(32, 126));
            if (c == CH_DOLLAR || c == CH_STAR) c = ".";
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    task automatic random_line();
        int    kind;
        string body;
        string s;
        int    n;
        steady = ($urandom_range(0, 7) == 0);
        kind   = $urandom_range(0, 99);
        if ($urandom_range(0, 5) == 0) begin
            body = filler(4);
            if ($urandom_range(0, 1)) body = {"GN", body};
            else body = {"GP", body};
        end else begin
            body = talker_head($urandom_range(0, 7));
        end
        body = {body, filler($urandom_range(0, 12))};
        s = checked(body, 1'($urandom_range(0, 1)));
        n = s.len();
        if (kind < 60) begin
            if ($urandom_range(0, 9) == 0) s = {s.substr(0, n - 2), "0"};
            send_text(s);
            if ($urandom_range(0, 1)) send_byte(CH_CR);
            send_byte(CH_LF);
        end else if (kind < 80) begin
            case ($urandom_range(0, 5))
                0: s = s.substr(1, n - 1);
                1: s = {"$", body};
                2: s = s.substr(0, n - 2);
                3: s = {s, "A"};
                4: s = {"$GP", s};
                default: s = {s.substr(0, n - 3), "*", s.substr(n - 2, n - 1)};
            endcase
            send_text({s, "\n"});
        end else if (kind < 96) begin
            repeat ($urandom_range(1, 15)) send_byte(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) send_byte(CH_LF);
        end else begin
            // straddle the capacity: some fit exactly, some overflow
            send_text({"$", filler($urandom_range(126, 133)), "\n"});
        end
    endtask

    initial begin
        string s;
        int    start;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every known type, both talkers, both hex cases
        for (int k = 0; k < NUM_PREFIX; k++) begin
            send_text({checked({talker_head(k), "12,4807.038,N"}, k[0]), "\r\n"});
        end
        send_text({checked("GPXYZ,1", 1'b0), "\n"});
        send_text({checked("GP", 1'b1), "\n"});
        // checksum and framing faults
        send_text("$GPRMC,5*FF\n");
        send_text("#GPGGA*00\n");
        send_text("$GPGSV,1,2\n");
        send_text("$GPGSA*4\n");
        send_text("$GPGSA*4AB\n");
        send_text("$GPGSA*G1\n");
        send_text("$GP**1\n");
        send_text("*00\n");
        send_text("$\n");
        // empty lines give nothing
        send_text("\n\r\n");
        // a dollar in mid-line restarts the line
        send_text({"$GPGG", checked("GNRMC,9", 1'b1), "\n"});
        // a carriage return inside a line is skipped
        s = checked("GPGGA,7", 1'b0);
        send_text({s.substr(0, 3), "\r", s.substr(4, s.len() - 1), "\n"});
        // zero byte and all-ones byte as ordinary characters
        send_byte(CH_DOLLAR);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_text("*FF\n");
        // longest held line, then one character too many
        send_text({checked(filler(123), 1'b0), "\n"});
        send_text({"$", filler(127), "\n"});
        // bytes after an overflow are dropped up to the newline
        send_text({"$", filler(129), "$GPGGA,\n"});

        start = bytes_sent;
        while (bytes_sent - start < RANDOM_BYTES) random_line();
        steady = 1'b0;
        send_byte(CH_LF);

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_due != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
